// ===== rtl/slte_pkg.sv =====
// ----------------------------------------------------------------------------
// slte_pkg
// Types, codes and character helpers for the string literal text encoder.
// ----------------------------------------------------------------------------
package slte_pkg;

  localparam int MAX_RUN   = 5;
  localparam int RUN_CNT_W = 3;

  typedef enum logic [1:0] {
    MODE_HEX  = 2'd0,
    MODE_DEC  = 2'd1,
    MODE_B64  = 2'd2,
    MODE_PASS = 2'd3
  } mode_t;

  localparam logic CMD_DATA = 1'b0;
  localparam logic CMD_END  = 1'b1;

  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_COMMA  = 8'h2c;
  localparam logic [7:0] CH_LBRK   = 8'h5b;
  localparam logic [7:0] CH_RBRK   = 8'h5d;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_EQ     = 8'h3d;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_PLUS   = 8'h2b;
  localparam logic [7:0] CH_SLASH  = 8'h2f;

  typedef struct packed {
    logic       cmd;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last_of_run;
  } out_item_t;

  typedef logic [MAX_RUN-1:0][7:0] run_chars_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) return CH_ZERO + {4'd0, nib};
    else             return CH_LOWER_A + {4'd0, nib} - 8'd10;
  endfunction

  function automatic logic [7:0] b64_char(input logic [5:0] idx);
    if (idx < 6'd26)      return CH_UPPER_A + {2'd0, idx};
    else if (idx < 6'd52) return CH_LOWER_A + {2'd0, idx} - 8'd26;
    else if (idx < 6'd62) return CH_ZERO + {2'd0, idx} - 8'd52;
    else if (idx == 6'd62) return CH_PLUS;
    else                  return CH_SLASH;
  endfunction

  // Binary to three BCD digits, shift-and-add-3 over the eight input bits.
  function automatic logic [11:0] to_bcd(input logic [7:0] bin);
    logic [11:0] bcd;
    bcd = '0;
    for (int i = 7; i >= 0; i--) begin
      if (bcd[3:0] > 4'd4)  bcd[3:0]  = bcd[3:0] + 4'd3;
      if (bcd[7:4] > 4'd4)  bcd[7:4]  = bcd[7:4] + 4'd3;
      if (bcd[11:8] > 4'd4) bcd[11:8] = bcd[11:8] + 4'd3;
      bcd = {bcd[10:0], bin[i]};
    end
    return bcd;
  endfunction

endpackage

// ===== rtl/string_literal_text_encoder.sv =====
// ----------------------------------------------------------------------------
// string_literal_text_encoder
// Encodes string bytes as hex escapes, a decimal list, quoted base64 or
// plain bytes, a run of up to five output characters per request.
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  in       | in_valid/in_stall   | in_data   (cmd, data_byte)
//  out      | out_valid/out_stall | out_data  (out_char, last_of_run)
//  cfg      | cfg_valid/cfg_ready | cfg_data  (encode_mode)
//
// An input request is encoded in the cycle it is accepted into a run of zero
// to five characters; runs drain from a two-run buffer one character per
// cycle while out_stall is low. in_stall is high only while both run slots
// are full. Reset clears the run buffer, the string state and sets pass mode.
// Requests that make no characters leave no trace on the output.
module string_literal_text_encoder
  import slte_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [1:0] cfg_data
);

  mode_t            mode;
  logic             started;
  logic [1:0]       fill;
  logic [1:0][7:0]  pending;

  logic                 cur_valid, nxt_valid;
  run_chars_t           cur_chars, nxt_chars;
  logic [RUN_CNT_W-1:0] cur_cnt, nxt_cnt, idx;

  // encoder
  run_chars_t           enc_raw, enc_chars;
  logic [RUN_CNT_W-1:0] enc_raw_cnt, enc_cnt;
  logic                 enc_skip;
  logic [1:0]           fill_eff, fill_next;
  logic [11:0]          bcd;
  logic [7:0]           b, b0, b1;
  logic                 accept, has_run, cur_last, pop, cur_free;

  assign cfg_ready = 1'b1;
  assign in_stall  = nxt_valid;
  assign accept    = in_valid && !in_stall;

  assign b        = in_data.data_byte;
  assign b0       = pending[0];
  assign b1       = pending[1];
  assign fill_eff = (fill == 2'd3) ? 2'd0 : fill;
  assign bcd      = to_bcd(b);

  always_comb begin
    enc_raw     = '0;
    enc_raw_cnt = '0;
    enc_skip    = 1'b0;
    fill_next   = fill_eff;
    if (in_data.cmd == CMD_DATA) begin
      case (mode)
        MODE_HEX: begin
          enc_raw[0]  = CH_BSLASH;
          enc_raw[1]  = CH_X;
          enc_raw[2]  = hex_char(b[7:4]);
          enc_raw[3]  = hex_char(b[3:0]);
          enc_raw_cnt = RUN_CNT_W'(4);
        end
        MODE_DEC: begin
          enc_raw[0] = started ? CH_COMMA : CH_LBRK;
          if (b >= 8'd100) begin
            enc_raw[1]  = CH_ZERO + {4'd0, bcd[11:8]};
            enc_raw[2]  = CH_ZERO + {4'd0, bcd[7:4]};
            enc_raw[3]  = CH_ZERO + {4'd0, bcd[3:0]};
            enc_raw_cnt = RUN_CNT_W'(4);
          end else if (b >= 8'd10) begin
            enc_raw[1]  = CH_ZERO + {4'd0, bcd[7:4]};
            enc_raw[2]  = CH_ZERO + {4'd0, bcd[3:0]};
            enc_raw_cnt = RUN_CNT_W'(3);
          end else begin
            enc_raw[1]  = CH_ZERO + {4'd0, bcd[3:0]};
            enc_raw_cnt = RUN_CNT_W'(2);
          end
        end
        MODE_B64: begin
          // slot 0 holds the opening quote; drop it once the string runs
          enc_raw[0] = CH_QUOTE;
          enc_skip   = started;
          if (fill_eff < 2'd2) begin
            enc_raw_cnt = RUN_CNT_W'(1);
            fill_next   = fill_eff + 2'd1;
          end else begin
            enc_raw[1]  = b64_char(b0[7:2]);
            enc_raw[2]  = b64_char({b0[1:0], b1[7:4]});
            enc_raw[3]  = b64_char({b1[3:0], b[7:6]});
            enc_raw[4]  = b64_char(b[5:0]);
            enc_raw_cnt = RUN_CNT_W'(5);
            fill_next   = 2'd0;
          end
        end
        default: begin
          enc_raw[0]  = b;
          enc_raw_cnt = RUN_CNT_W'(1);
        end
      endcase
    end else begin
      fill_next = 2'd0;
      case (mode)
        MODE_DEC: begin
          enc_raw[0]  = CH_LBRK;
          enc_raw[1]  = CH_RBRK;
          enc_raw_cnt = RUN_CNT_W'(2);
          enc_skip    = started;
        end
        MODE_B64: begin
          if (!started) begin
            enc_raw[0]  = CH_QUOTE;
            enc_raw[1]  = CH_QUOTE;
            enc_raw_cnt = RUN_CNT_W'(2);
          end else if (fill_eff == 2'd1) begin
            enc_raw[0]  = b64_char(b0[7:2]);
            enc_raw[1]  = b64_char({b0[1:0], 4'd0});
            enc_raw[2]  = CH_EQ;
            enc_raw[3]  = CH_EQ;
            enc_raw[4]  = CH_QUOTE;
            enc_raw_cnt = RUN_CNT_W'(5);
          end else if (fill_eff == 2'd2) begin
            enc_raw[0]  = b64_char(b0[7:2]);
            enc_raw[1]  = b64_char({b0[1:0], b1[7:4]});
            enc_raw[2]  = b64_char({b1[3:0], 2'd0});
            enc_raw[3]  = CH_EQ;
            enc_raw[4]  = CH_QUOTE;
            enc_raw_cnt = RUN_CNT_W'(5);
          end else begin
            enc_raw[0]  = CH_QUOTE;
            enc_raw_cnt = RUN_CNT_W'(1);
          end
        end
        default: begin
          enc_raw_cnt = '0;
        end
      endcase
    end
  end

  always_comb begin
    enc_chars = enc_raw;
    enc_cnt   = enc_raw_cnt;
    if (enc_skip) begin
      enc_chars = {8'd0, enc_raw[MAX_RUN-1:1]};
      enc_cnt   = enc_raw_cnt - RUN_CNT_W'(1);
    end
  end

  assign has_run  = accept && (enc_cnt != '0);
  assign cur_last = (idx == cur_cnt - RUN_CNT_W'(1));
  assign pop      = cur_valid && !out_stall;
  assign cur_free = !cur_valid || (pop && cur_last);

  assign out_valid            = cur_valid;
  assign out_data.out_char    = cur_chars[idx];
  assign out_data.last_of_run = cur_last;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_PASS;
      started   <= 1'b0;
      fill      <= 2'd0;
      cur_valid <= 1'b0;
      nxt_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (cfg_valid && cfg_ready) mode <= mode_t'(cfg_data);
      if (accept) begin
        started <= (in_data.cmd == CMD_DATA);
        fill    <= fill_next;
      end
      if (cur_free) begin
        idx <= '0;
        if (nxt_valid) begin
          cur_valid <= 1'b1;
          nxt_valid <= 1'b0;
        end else begin
          cur_valid <= has_run;
        end
      end else begin
        if (pop) idx <= idx + RUN_CNT_W'(1);
        if (has_run) nxt_valid <= 1'b1;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (accept && in_data.cmd == CMD_DATA && mode == MODE_B64 && fill_eff < 2'd2)
      pending[fill_eff[0]] <= b;
    if (cur_free) begin
      if (nxt_valid) begin
        cur_chars <= nxt_chars;
        cur_cnt   <= nxt_cnt;
      end else if (has_run) begin
        cur_chars <= enc_chars;
        cur_cnt   <= enc_cnt;
      end
    end else if (has_run) begin
      nxt_chars <= enc_chars;
      nxt_cnt   <= enc_cnt;
    end
  end

`ifndef NO_ASSERTIONS
  a_idx_in_run: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> (idx < cur_cnt))
    else $error("character index beyond run length");

  a_run_nonempty: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> (cur_cnt != '0) && (cur_cnt <= RUN_CNT_W'(MAX_RUN)))
    else $error("run length out of range");

  a_order: assert property (@(posedge clk) disable iff (rst)
    nxt_valid |-> cur_valid)
    else $error("waiting run without a draining run");

  a_fill: assert property (@(posedge clk) disable iff (rst)
    fill != 2'd3)
    else $error("base64 group fill out of range");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    accept && in_data.cmd == CMD_END |=> !started && fill == 2'd0)
    else $error("string state not cleared at end of string");
`endif

endmodule
